// File: rtl/assert_macros.svh
// Assertion macros shared by the convolution block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given reset is low.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_CLK(label, prop, msg) \
  `ASSERT_ON(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/c2d_pkg.sv
// Shared types and constants of the 3x3 convolution block.
package c2d_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_WEIGHT  = 2'd0,
    FUNC_BIAS    = 2'd1,
    FUNC_PIXEL   = 2'd2,
    FUNC_COMPUTE = 2'd3
  } func_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_IN_CH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_OUT_CH = 2'd3
  } reg_e;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BIAS_W     = 32;
  localparam int unsigned PROD_W     = 32;

  // Store dimensions; the stream fields and registers are sized for these.
  localparam int unsigned MAX_OUT_CHANNELS = 64;
  localparam int unsigned MAX_IN_CHANNELS  = 8;
  localparam int unsigned MAX_HEIGHT       = 64;
  localparam int unsigned MAX_WIDTH        = 64;
  localparam int unsigned KDIM             = 3;

  // Register reset values.
  localparam logic [3:0] RST_IN_CH  = 4'd3;
  localparam logic [6:0] RST_HEIGHT = 7'd32;
  localparam logic [6:0] RST_WIDTH  = 7'd32;
  localparam logic [6:0] RST_OUT_CH = 7'd64;

  // Saturation limits of the Q16.16 result.
  localparam logic [31:0] RESULT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] RESULT_MIN = 32'h8000_0000;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic add_en;
  } mac_ctl_t;

endpackage

// File: rtl/c2d_ram.sv
// Generic single-port RAM with registered read data.
module c2d_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/c2d_mac.sv
// Shared multiply-accumulate unit: one registered product per cycle into a wide sum.
`include "assert_macros.svh"

module c2d_mac #(
  parameter int unsigned ACC_W = 40
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  c2d_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [c2d_pkg::SAMPLE_W-1:0] pixel_i,
  input  logic signed [c2d_pkg::SAMPLE_W-1:0] weight_i,
  input  logic signed [c2d_pkg::BIAS_W-1:0]   bias_i,
  output logic signed [ACC_W-1:0]             acc_o
);
  import c2d_pkg::*;

  logic                     pv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Product stage; pv_q marks a product waiting to be summed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= pixel_i * weight_i;
    end
  end

  // Accumulator: clear, add a product, or add the bias.
  always_ff @(posedge clk_i) begin
    priority if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end else if (ctl_i.add_en) begin
      acc_q <= acc_q + ACC_W'(bias_i);
    end
  end

  assign acc_o = acc_q;

  `ASSERT_CLK(a_bias_after_drain, ctl_i.add_en |-> !pv_q,
              "bias add collides with a pending product")
  `ASSERT_CLK(a_clear_when_empty, ctl_i.clear |-> !pv_q,
              "accumulator cleared while a product is pending")

endmodule

// File: rtl/conv2d_3x3_pad1_top.sv
// Top level of the 3x3 convolution block: stores, sequencer and output register.
//
//  Channel   Dir  Handshake                  Content
//  s_axis    in   s_axis_tvalid/tready       load weight, bias or pixel; compute request
//  m_axis    out  m_axis_tvalid/tready       one output pixel per compute request
//  apb       in   psel/penable/pwrite/pready four size and count registers
//
//  A load is accepted while idle. A compute request keeps the block busy as it walks
//  each kernel tap of every input channel in use: one multiply-accumulate per in-map
//  tap through the single shared MAC, then pipeline drain, bias add and saturation.
//  Requests outside the configured sizes go straight to output with request_ok low.
//  Reset restores the registers; the stores are not cleared.
//  A result waits in the output register; loads are taken while it waits.
`include "assert_macros.svh"

module conv2d_3x3_pad1_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: out_channel[5:0], in_channel[8:6], row[14:9], col[20:15], value[52:21]
  input  logic [c2d_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  logic [c2d_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: result[31:0]
  output logic [c2d_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: saturated[0], request_ok[1]
  output logic [c2d_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c2d_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [c2d_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import c2d_pkg::*;

  localparam int unsigned Pad    = KDIM / 2;
  localparam int unsigned Taps   = KDIM * KDIM;
  localparam int unsigned WDepth = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * Taps;
  localparam int unsigned FDepth = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned WAw    = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int unsigned FAw    = (FDepth > 1) ? $clog2(FDepth) : 1;
  localparam int unsigned BAw    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int unsigned ChW    = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int unsigned KW     = (KDIM > 1) ? $clog2(KDIM) : 1;
  localparam int unsigned AccW   = 33 + $clog2(MAX_IN_CHANNELS * Taps + 1);
  localparam int unsigned PosW   = 9;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // Input fields.
  func_e                      func;
  logic [5:0]                 in_oc;
  logic [2:0]                 in_ic;
  logic [5:0]                 in_row;
  logic [5:0]                 in_col;
  logic [31:0]                in_value;

  assign func     = func_e'(s_axis_tuser);
  assign in_oc    = s_axis_tdata[5:0];
  assign in_ic    = s_axis_tdata[8:6];
  assign in_row   = s_axis_tdata[14:9];
  assign in_col   = s_axis_tdata[20:15];
  assign in_value = s_axis_tdata[52:21];

  // Configuration registers.
  logic [3:0] cfg_in_q;
  logic [6:0] cfg_h_q, cfg_w_q, cfg_out_q;
  logic       cfg_we;
  reg_e       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_e'(paddr[3:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_in_q  <= RST_IN_CH;
      cfg_h_q   <= RST_HEIGHT;
      cfg_w_q   <= RST_WIDTH;
      cfg_out_q <= RST_OUT_CH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IN_CH:  cfg_in_q  <= pwdata[3:0];
        REG_HEIGHT: cfg_h_q   <= pwdata[6:0];
        REG_WIDTH:  cfg_w_q   <= pwdata[6:0];
        REG_OUT_CH: cfg_out_q <= pwdata[6:0];
        default:    cfg_in_q  <= cfg_in_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IN_CH:  prdata = CFG_DATA_W'(cfg_in_q);
      REG_HEIGHT: prdata = CFG_DATA_W'(cfg_h_q);
      REG_WIDTH:  prdata = CFG_DATA_W'(cfg_w_q);
      REG_OUT_CH: prdata = CFG_DATA_W'(cfg_out_q);
      default:    prdata = '0;
    endcase
  end

  // Sizes in use, limited to the store dimensions.
  logic [3:0] n_in;
  logic [6:0] n_out, lim_h, lim_w;

  assign n_in  = (cfg_in_q > MAX_IN_CHANNELS) ? 4'(MAX_IN_CHANNELS) : cfg_in_q;
  assign n_out = (cfg_out_q > MAX_OUT_CHANNELS) ? 7'(MAX_OUT_CHANNELS) : cfg_out_q;
  assign lim_h = (cfg_h_q > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg_h_q;
  assign lim_w = (cfg_w_q > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg_w_q;

  // Sequencer registers.
  state_e          state_q, state_d;
  logic [5:0]      oc_q, row_q, col_q;
  logic            ok_q;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [KW-1:0]   kh_q, kh_d, kw_q, kw_d;
  logic [WAw-1:0]  wa_q, wa_d;
  logic            tap_v_q, tap_v_d;
  logic            drain_q, drain_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_data_q;
  logic            out_sat_q, out_ok_q;
  logic            out_load;

  logic            in_acc, req, req_ok;
  logic            last_kw, last_kh, last_ch;
  logic [PosW-1:0] tap_y, tap_x;
  logic            tap_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign req           = in_acc && (func == FUNC_COMPUTE);
  assign req_ok        = (7'(in_oc) < n_out) && (7'(in_row) < lim_h) && (7'(in_col) < lim_w);

  // Tap position relative to the requested pixel; negative means padding.
  assign tap_y  = PosW'(row_q) + PosW'(kh_q) - PosW'(Pad);
  assign tap_x  = PosW'(col_q) + PosW'(kw_q) - PosW'(Pad);
  assign tap_ok = !tap_y[PosW-1] && !tap_x[PosW-1] &&
                  (tap_y < PosW'(lim_h)) && (tap_x < PosW'(lim_w));

  assign last_kw = (kw_q == KW'(KDIM - 1));
  assign last_kh = (kh_q == KW'(KDIM - 1));
  assign last_ch = (8'(ch_q) == 8'(n_in) - 8'd1);

  // Sequencer: tap walk over input channel, kernel row and kernel column, then drain, bias add and output.
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    kh_d    = kh_q;
    kw_d    = kw_q;
    wa_d    = wa_q;
    tap_v_d = 1'b0;
    drain_d = drain_q;
    unique case (state_q)
      ST_IDLE: begin
        ch_d    = '0;
        kh_d    = '0;
        kw_d    = '0;
        drain_d = 1'b0;
        wa_d    = WAw'(in_oc) * WAw'(MAX_IN_CHANNELS * Taps);
        if (req) begin
          if (!req_ok) begin
            state_d = ST_OUT;
          end else if (n_in == 4'd0) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        tap_v_d = tap_ok;
        wa_d    = wa_q + WAw'(1);
        if (last_kw) begin
          kw_d = '0;
          if (last_kh) begin
            kh_d = '0;
            ch_d = ch_q + ChW'(1);
            if (last_ch) begin
              state_d = ST_DRAIN;
            end
          end else begin
            kh_d = kh_q + KW'(1);
          end
        end else begin
          kw_d = kw_q + KW'(1);
        end
      end
      ST_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_v_q     <= 1'b0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_v_q     <= tap_v_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    kh_q <= kh_d;
    kw_q <= kw_d;
    wa_q <= wa_d;
    if (req) begin
      oc_q  <= in_oc;
      row_q <= in_row;
      col_q <= in_col;
      ok_q  <= req_ok;
    end
  end

  // Store ports: writes while idle, tap reads while running.
  logic             w_we, f_we, b_we;
  logic [WAw-1:0]   w_addr;
  logic [FAw-1:0]   f_addr;
  logic [BAw-1:0]   b_addr;
  logic [SAMPLE_W-1:0] w_rdata, f_rdata;
  logic [BIAS_W-1:0]   b_rdata;

  assign w_we = in_acc && (func == FUNC_WEIGHT) && (in_oc < MAX_OUT_CHANNELS) &&
                (in_ic < MAX_IN_CHANNELS) && (in_row < KDIM) && (in_col < KDIM);
  assign b_we = in_acc && (func == FUNC_BIAS) && (in_oc < MAX_OUT_CHANNELS);
  assign f_we = in_acc && (func == FUNC_PIXEL) && (in_ic < MAX_IN_CHANNELS) &&
                (in_row < MAX_HEIGHT) && (in_col < MAX_WIDTH);

  always_comb begin
    if (state_q == ST_RUN) begin
      w_addr = wa_q;
      f_addr = FAw'(ch_q) * FAw'(MAX_HEIGHT * MAX_WIDTH) + FAw'(tap_y) * FAw'(MAX_WIDTH) +
               FAw'(tap_x);
    end else begin
      w_addr = WAw'(in_oc) * WAw'(MAX_IN_CHANNELS * Taps) + WAw'(in_ic) * WAw'(Taps) +
               WAw'(in_row) * WAw'(KDIM) + WAw'(in_col);
      f_addr = FAw'(in_ic) * FAw'(MAX_HEIGHT * MAX_WIDTH) + FAw'(in_row) * FAw'(MAX_WIDTH) +
               FAw'(in_col);
    end
  end

  // The bias of the requested channel is read at acceptance and held.
  assign b_addr = (state_q == ST_IDLE) ? BAw'(in_oc) : BAw'(oc_q);

  c2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(WDepth)) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .addr_i (w_addr),
    .wdata_i(in_value[SAMPLE_W-1:0]),
    .rdata_o(w_rdata)
  );

  c2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(FDepth)) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .addr_i (f_addr),
    .wdata_i(in_value[SAMPLE_W-1:0]),
    .rdata_o(f_rdata)
  );

  c2d_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT_CHANNELS)) u_bias_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .addr_i (b_addr),
    .wdata_i(in_value),
    .rdata_o(b_rdata)
  );

  // Shared multiply-accumulate.
  mac_ctl_t               mac_ctl;
  logic signed [AccW-1:0] acc;

  assign mac_ctl.clear  = req;
  assign mac_ctl.mul_en = tap_v_q;
  assign mac_ctl.add_en = (state_q == ST_SUM);

  c2d_mac #(.ACC_W(AccW)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .pixel_i ($signed(f_rdata)),
    .weight_i($signed(w_rdata)),
    .bias_i  ($signed(b_rdata)),
    .acc_o   (acc)
  );

  // Saturation to signed 32 bits and the output register.
  logic        sat_hi, sat_lo;
  logic [31:0] sat_val;

  assign sat_hi  = !acc[AccW-1] && (acc[AccW-2:31] != '0);
  assign sat_lo  = acc[AccW-1] && (acc[AccW-2:31] != '1);
  assign sat_val = sat_hi ? RESULT_MAX : (sat_lo ? RESULT_MIN : acc[31:0]);

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= ok_q ? sat_val : '0;
      out_sat_q  <= ok_q && (sat_hi || sat_lo);
      out_ok_q   <= ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_ok_q, out_sat_q};

  `ASSERT_CLK(a_out_not_overwritten,
              (state_q == ST_OUT) && out_valid_q && !m_axis_tready |=> (state_q == ST_OUT),
              "pending result would be overwritten")
  `ASSERT_CLK(a_bad_request_zero,
              m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0],
              "out-of-range request returned nonzero data")
  `ASSERT_CLK(a_weight_walk,
              (state_q == ST_RUN) |=> (wa_q == $past(wa_q) + WAw'(1)),
              "weight address did not advance by one tap")

endmodule

// File: dv/conv2d_3x3_pad1_top_tb.sv
// Self-checking testbench of the 3x3 convolution block with stream and APB stimulus.
module conv2d_3x3_pad1_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c2d_pkg::*;

  localparam int MAX_OC       = 64;
  localparam int MAX_IC       = 8;
  localparam int MAX_H        = 64;
  localparam int MAX_W        = 64;
  localparam int KSIZE        = 3;
  localparam int WEIGHT_DEPTH = MAX_OC * MAX_IC * KSIZE * KSIZE;
  localparam int MAP_DEPTH    = MAX_IC * MAX_H * MAX_W;

  localparam int ITEM_TARGET  = 1150;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;

  localparam longint SUM_MAX = longint'(32'sh7fff_ffff);
  localparam longint SUM_MIN = longint'(32'sh8000_0000);

  // One input beat, unpacked from the stream fields.
  typedef struct packed {
    func_e       func;
    logic [5:0]  oc;
    logic [2:0]  ic;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
  } in_beat_t;

  // One output pixel as the block returns it.
  typedef struct packed {
    logic [31:0] result;
    logic        sat;
    logic        ok;
  } pixel_t;

  // Mirror of the block's stores and registers, plus the queue of pixels still owed.
  class conv_tracker;
    logic [3:0]         in_ch_reg;
    logic [6:0]         height_reg;
    logic [6:0]         width_reg;
    logic [6:0]         out_ch_reg;
    logic signed [15:0] weights [WEIGHT_DEPTH];
    bit                 weight_set [WEIGHT_DEPTH];
    logic signed [31:0] biases [MAX_OC];
    bit                 bias_set [MAX_OC];
    logic signed [15:0] fmap [MAP_DEPTH];
    bit                 fmap_set [MAP_DEPTH];
    pixel_t             expected_pixels [$];
    int errors, beats, ignored, pixels, clipped, refused;

    function new();
      in_ch_reg  = RST_IN_CH;
      height_reg = RST_HEIGHT;
      width_reg  = RST_WIDTH;
      out_ch_reg = RST_OUT_CH;
      errors = 0;
      beats = 0;
      ignored = 0;
      pixels = 0;
      clipped = 0;
      refused = 0;
    endfunction

    function void report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endfunction

    // Register values above the store sizes act as the store size.
    function int n_in_use();
      return (in_ch_reg > MAX_IC) ? MAX_IC : int'(in_ch_reg);
    endfunction
    function int height_use();
      return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction
    function int width_use();
      return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction
    function int out_use();
      return (out_ch_reg > MAX_OC) ? MAX_OC : int'(out_ch_reg);
    endfunction

    function int weight_idx(int oc, int ic, int kr, int kc);
      return ((oc * MAX_IC + ic) * KSIZE + kr) * KSIZE + kc;
    endfunction
    function int map_idx(int ic, int r, int c);
      return (ic * MAX_H + r) * MAX_W + c;
    endfunction

    function void set_register(reg_e r, logic [31:0] v);
      case (r)
        REG_IN_CH:  in_ch_reg  = v[3:0];
        REG_HEIGHT: height_reg = v[6:0];
        REG_WIDTH:  width_reg  = v[6:0];
        default:    out_ch_reg = v[6:0];
      endcase
    endfunction

    function logic [31:0] register_value(reg_e r);
      case (r)
        REG_IN_CH:  return {28'd0, in_ch_reg};
        REG_HEIGHT: return {25'd0, height_reg};
        REG_WIDTH:  return {25'd0, width_reg};
        default:    return {25'd0, out_ch_reg};
      endcase
    endfunction

    function bit in_range(int oc, int row, int col);
      return oc < out_use() && row < height_use() && col < width_use();
    endfunction

    // A request is safe when every store entry it reads has been written.
    function bit request_safe(int oc, int row, int col);
      int c, kh, kw, y, x;
      if (!in_range(oc, row, col)) return 1'b1;
      if (!bias_set[oc]) return 1'b0;
      for (c = 0; c < n_in_use(); c++) begin
        for (kh = 0; kh < KSIZE; kh++) begin
          for (kw = 0; kw < KSIZE; kw++) begin
            y = row + kh - 1;
            x = col + kw - 1;
            if (y >= 0 && x >= 0 && y < height_use() && x < width_use()) begin
              if (!fmap_set[map_idx(c, y, x)] || !weight_set[weight_idx(oc, c, kh, kw)])
                return 1'b0;
            end
          end
        end
      end
      return 1'b1;
    endfunction

    // Exact sum over channels and in-map taps plus bias, clipped once to 32 bits.
    function pixel_t predict_pixel(int oc, int row, int col);
      pixel_t px;
      longint acc;
      int c, kh, kw, y, x;
      px = '0;
      if (!in_range(oc, row, col)) return px;
      acc = 0;
      for (c = 0; c < n_in_use(); c++) begin
        for (kh = 0; kh < KSIZE; kh++) begin
          for (kw = 0; kw < KSIZE; kw++) begin
            y = row + kh - 1;
            x = col + kw - 1;
            if (y >= 0 && x >= 0 && y < height_use() && x < width_use())
              acc += longint'(fmap[map_idx(c, y, x)]) *
                     longint'(weights[weight_idx(oc, c, kh, kw)]);
          end
        end
      end
      acc += longint'(biases[oc]);
      px.ok = 1'b1;
      if (acc > SUM_MAX) begin
        acc = SUM_MAX;
        px.sat = 1'b1;
      end else if (acc < SUM_MIN) begin
        acc = SUM_MIN;
        px.sat = 1'b1;
      end
      px.result = acc[31:0];
      return px;
    endfunction

    // Applies an accepted input beat; returns 1 when the block ignores it.
    function bit note_beat(in_beat_t b);
      beats++;
      case (b.func)
        FUNC_WEIGHT: begin
          if (b.row < KSIZE && b.col < KSIZE) begin
            weights[weight_idx(b.oc, b.ic, b.row, b.col)] = b.value[15:0];
            weight_set[weight_idx(b.oc, b.ic, b.row, b.col)] = 1'b1;
          end else begin
            ignored++;
            return 1'b1;
          end
        end
        FUNC_BIAS: begin
          biases[b.oc] = b.value;
          bias_set[b.oc] = 1'b1;
        end
        FUNC_PIXEL: begin
          fmap[map_idx(b.ic, b.row, b.col)] = b.value[15:0];
          fmap_set[map_idx(b.ic, b.row, b.col)] = 1'b1;
        end
        default: expected_pixels = {expected_pixels, predict_pixel(b.oc, b.row, b.col)};
      endcase
      return 1'b0;
    endfunction

    // Compares an accepted output beat with the oldest pixel still owed.
    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("output pixel %h arrived with no request waiting", got.result));
        return;
      end
      want = expected_pixels.pop_front();
      if (want.sat) clipped++;
      if (!want.ok) refused++;
      if (got.result !== want.result)
        report($sformatf("pixel %0d: result %h, expected %h", pixels, got.result, want.result));
      if (got.sat !== want.sat)
        report($sformatf("pixel %0d: saturated %b, expected %b", pixels, got.sat, want.sat));
      if (got.ok !== want.ok)
        report($sformatf("pixel %0d: request_ok %b, expected %b", pixels, got.ok, want.ok));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  conv_tracker trk;
  int          items_counted = 0;
  int          settings_run = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_stall_on = 1'b1;
  bit          rx_hold_req = 1'b0;

  conv2d_3x3_pad1_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sender gap: mostly none, sometimes short, rarely a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall length, never zero.
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Q8.8 sample in the low half, random upper bits, with extremes and small values mixed in.
  function automatic logic [31:0] rand_sample();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       v[15:0] = 16'h7fff;
      1:       v[15:0] = 16'h8000;
      2:       v[15:0] = 16'h0000;
      3, 4, 5: v[15:0] = 16'($urandom_range(0, 511)) - 16'd256;
      default: ;
    endcase
    return v;
  endfunction

  // Q16.16 bias with the same mix.
  function automatic logic [31:0] rand_bias();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'h0000_0000;
      3, 4, 5: v = $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
      default: ;
    endcase
    return v;
  endfunction

  // Coordinate below n, biased toward the two borders.
  function automatic int pick_coord(int n);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Offers one input beat, waits for it to be taken, then idles at random.
  task automatic send_item(func_e f, int oc, int ic, int row, int col, logic [31:0] value);
    in_beat_t b;
    int       gap;
    b.func  = f;
    b.oc    = 6'(oc);
    b.ic    = 3'(ic);
    b.row   = 6'(row);
    b.col   = 6'(col);
    b.value = value;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, b.value, b.col, b.row, b.ic, b.oc};
    s_axis_tuser  <= b.func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!trk.note_beat(b)) items_counted++;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_e r, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    trk.set_register(r, data);
    @(posedge clk_i);
  endtask

  // APB read with a check against the mirrored register.
  task automatic read_reg(reg_e r);
    logic [31:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data !== trk.register_value(r))
      trk.report($sformatf("register %s reads %h, expected %h",
                           r.name(), data, trk.register_value(r)));
    @(posedge clk_i);
  endtask

  // Waits until every owed pixel has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (trk.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four registers on an idle block, junk in the unused upper bits; reads them back.
  task automatic apply_setting(int i, int h, int w, int o);
    drain();
    write_reg(REG_IN_CH,  ($urandom & ~32'hf)  | (32'(i) & 32'hf));
    write_reg(REG_HEIGHT, ($urandom & ~32'h7f) | (32'(h) & 32'h7f));
    write_reg(REG_WIDTH,  ($urandom & ~32'h7f) | (32'(w) & 32'h7f));
    write_reg(REG_OUT_CH, ($urandom & ~32'h7f) | (32'(o) & 32'h7f));
    read_reg(REG_IN_CH);
    read_reg(REG_HEIGHT);
    read_reg(REG_WIDTH);
    read_reg(REG_OUT_CH);
    settings_run++;
  endtask

  // Loads the bias, pixels and weights that a request reads, refreshing a few at random.
  task automatic load_neighborhood(int oc, int row, int col);
    int c, kh, kw, y, x;
    if (!trk.bias_set[oc] || $urandom_range(0, 7) == 0)
      send_item(FUNC_BIAS, oc, $urandom, $urandom, $urandom, rand_bias());
    for (c = 0; c < trk.n_in_use(); c++) begin
      for (kh = 0; kh < KSIZE; kh++) begin
        for (kw = 0; kw < KSIZE; kw++) begin
          y = row + kh - 1;
          x = col + kw - 1;
          if (y >= 0 && x >= 0 && y < trk.height_use() && x < trk.width_use()) begin
            if (!trk.fmap_set[trk.map_idx(c, y, x)] || $urandom_range(0, 15) == 0)
              send_item(FUNC_PIXEL, $urandom, c, y, x, rand_sample());
            if (!trk.weight_set[trk.weight_idx(oc, c, kh, kw)] || $urandom_range(0, 15) == 0)
              send_item(FUNC_WEIGHT, oc, c, kh, kw, rand_sample());
          end
        end
      end
    end
  endtask

  // One random step: mostly a complete request sequence, otherwise noise.
  task automatic random_step();
    int    r, oc, row, col;
    func_e f;
    r = $urandom_range(0, 99);
    if (r < 75 && trk.out_use() > 0 && trk.height_use() > 0 && trk.width_use() > 0) begin
      oc  = pick_coord(trk.out_use());
      row = pick_coord(trk.height_use());
      col = pick_coord(trk.width_use());
      load_neighborhood(oc, row, col);
      // Now and then the sequence is cut short before its request.
      if ($urandom_range(0, 19) != 0)
        send_item(FUNC_COMPUTE, oc, $urandom, row, col, $urandom);
    end else if (r < 88) begin
      f = func_e'($urandom_range(0, 2));
      if (f == FUNC_WEIGHT && $urandom_range(0, 3) != 0)
        send_item(f, $urandom, $urandom, $urandom_range(0, 2), $urandom_range(0, 2),
                  rand_sample());
      else
        send_item(f, $urandom, $urandom, $urandom, $urandom,
                  (f == FUNC_BIAS) ? rand_bias() : rand_sample());
    end else begin
      oc  = $urandom_range(0, 63);
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
      if (trk.request_safe(oc, row, col))
        send_item(FUNC_COMPUTE, oc, $urandom, row, col, $urandom);
    end
  endtask

  // Runs one phase: fixed settings and extremes first, then mostly small random sizes.
  task automatic run_phase(int p);
    int i, h, w, o, start;
    case (p)
      0:       begin i = 1;  h = 3;   w = 4;   o = 2;   end
      1:       begin i = 2;  h = 5;   w = 6;   o = 3;   end
      2:       begin i = 0;  h = 4;   w = 4;   o = 5;   end
      3:       begin i = 8;  h = 64;  w = 64;  o = 64;  end
      4:       begin i = 15; h = 127; w = 127; o = 127; end
      5:       begin i = 3;  h = 0;   w = 8;   o = 4;   end
      6:       begin i = 3;  h = 8;   w = 0;   o = 4;   end
      7:       begin i = 2;  h = 6;   w = 6;   o = 0;   end
      8:       begin i = 1;  h = 1;   w = 64;  o = 64;  end
      9:       begin i = 4;  h = 64;  w = 1;   o = 2;   end
      default: begin
        i = $urandom_range(0, 4);
        h = $urandom_range(1, 8);
        w = $urandom_range(1, 8);
        o = $urandom_range(1, 6);
        if ($urandom_range(0, 4) == 0) h = $urandom_range(9, 127);
        if ($urandom_range(0, 4) == 0) w = $urandom_range(9, 127);
      end
    endcase
    apply_setting(i, h, w, o);
    // The first phase runs with no idling; later ones idle on most phases.
    tx_idle_on  = (p != 0) && ($urandom_range(0, 3) != 0);
    rx_stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
    // Hold the output side off for a long stretch so the block backs up its input.
    if (p == 1) rx_hold_req = 1'b1;
    start = items_counted;
    while (items_counted - start < PHASE_ITEMS && items_counted < ITEM_TARGET)
      random_step();
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left, stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (rx_stall_on && $urandom_range(0, 99) < 30) begin
        m_axis_tready <= 1'b0;
        stall_left = stall_len() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted output beat is checked against the oldest owed pixel.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready)
      trk.check_pixel('{result: m_axis_tdata, sat: m_axis_tuser[0], ok: m_axis_tuser[1]});
  end

  // Watchdog: ends the run when no beat moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Main sequence: reset, directed beats, random phases, final drain.
  initial begin : main
    int p;
    trk = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a one-pixel map with a single channel and tap.
    apply_setting(1, 1, 1, 1);
    send_item(FUNC_WEIGHT, 0, 0, 1, 1, {16'($urandom), 16'h7fff});
    send_item(FUNC_PIXEL, 0, 0, 0, 0, {16'($urandom), 16'h7fff});
    send_item(FUNC_BIAS, 0, 0, 0, 0, 32'h7fff_ffff);
    // Largest product on the largest bias clips high.
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 32'd0);
    // Kernel positions outside the store are dropped.
    send_item(FUNC_WEIGHT, 0, 0, 3, 1, $urandom);
    send_item(FUNC_WEIGHT, 0, 0, 1, 3, $urandom);
    send_item(FUNC_WEIGHT, 63, 7, 2, 2, 32'hffff_8000);
    send_item(FUNC_BIAS, 0, 0, 0, 0, 32'h8000_0000);
    send_item(FUNC_WEIGHT, 0, 0, 1, 1, {16'($urandom), 16'h8000});
    // Negative product on the smallest bias clips low.
    send_item(FUNC_COMPUTE, 0, 7, 0, 0, 32'hffff_ffff);
    send_item(FUNC_PIXEL, 0, 0, 0, 0, {16'($urandom), 16'h8000});
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 32'd0);
    // Requests beyond the configured channel or map are refused.
    send_item(FUNC_COMPUTE, 1, 0, 0, 0, 32'd0);
    send_item(FUNC_COMPUTE, 0, 0, 1, 0, 32'd0);
    send_item(FUNC_COMPUTE, 0, 0, 0, 1, 32'd0);
    send_item(FUNC_COMPUTE, 63, 7, 63, 63, 32'hffff_ffff);
    // Pixel far outside the configured map is still stored.
    send_item(FUNC_PIXEL, 63, 7, 63, 63, 32'hffff_ffff);
    send_item(FUNC_BIAS, 63, 7, 63, 63, 32'd0);
    send_item(FUNC_WEIGHT, 0, 0, 1, 1, 32'd0);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0, 32'd0);

    // Random phases over several register settings.
    p = 0;
    while (items_counted < ITEM_TARGET) begin
      run_phase(p);
      p++;
    end

    drain();
    $display("Run covered %0d input beats (%0d ignored loads) over %0d register settings.",
             trk.beats, trk.ignored, settings_run);
    $display("Checked %0d output pixels: %0d clipped, %0d refused as out of range.",
             trk.pixels, trk.clipped, trk.refused);
    if (trk.errors == 0 && trk.expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
